@@ src/fics_pkg.sv @@
package fics_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_ROWS  = MEM_BYTES / 4;
  localparam int ROW_W     = $clog2(MEM_ROWS);
  localparam int NUM_LANES = 4;
  localparam int GPR_COUNT = 16;

  localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);
  localparam logic [33:0] DATA_TOP  = 34'(MEM_BYTES - 4);
  localparam logic [3:0]  RF_TOP    = 4'(GPR_COUNT - 1);
  localparam logic [31:0] RF_TOP_RESET = 32'(MEM_BYTES - 4);

  typedef enum logic {
    ITEM_STEP = 1'b0,
    ITEM_LOAD = 1'b1
  } item_op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_R0_SKIP     = 3'd1,
    ST_FETCH_RANGE = 3'd2,
    ST_BAD_ADDR    = 3'd3,
    ST_BAD_OP      = 3'd4,
    ST_HALTED      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_LW  = 4'd1,
    OP_SW  = 4'd2,
    OP_BEQ = 4'd3,
    OP_J   = 4'd4
  } instr_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_REG,
    S_MEM
  } fsm_state_e;

  typedef struct packed {
    logic        opcode;
    logic [13:0] word_index;
    logic [31:0] word_data;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        next_pc;
    logic               halted;
    logic [31:0]        instr_word;
    logic               reg_write;
    logic [3:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_write;
    logic [15:0]        mem_address;
    logic               branch_taken;
  } result_t;

  function automatic logic [31:0] rf_reset_value(logic [3:0] idx);
    return (idx == RF_TOP) ? RF_TOP_RESET : '0;
  endfunction

endpackage

@@ src/fics_if.sv @@
interface fics_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [13:0] word_index;
  logic [31:0] word_data;

  modport source (output valid, output opcode, output word_index, output word_data,
                  input ready);
  modport sink (input valid, input opcode, input word_index, input word_data,
                output ready);
endinterface

interface fics_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        next_pc;
  logic               halted;
  logic [31:0]        instr_word;
  logic               reg_write;
  logic [3:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_write;
  logic [15:0]        mem_address;
  logic               branch_taken;

  modport source (output valid, output status, output next_pc, output halted,
                  output instr_word, output reg_write, output reg_index, output reg_value,
                  output mem_write, output mem_address, output branch_taken,
                  input ready);
  modport sink (input valid, input status, input next_pc, input halted,
                input instr_word, input reg_write, input reg_index, input reg_value,
                input mem_write, input mem_address, input branch_taken,
                output ready);
endinterface

@@ src/five_instruction_cpu_step.sv @@
// Small 16-register processor with 64 KB of byte memory. Each input word either
// loads one program word (little-endian) or executes one instruction (ADD, LW,
// SW, BEQ, J) and returns one result word with status, next pc and the register
// or memory write it made. Byte memory sits in four byte-lane RAMs with one port
// each and a registered read; the register file is a two-read-port RAM, also
// with a registered read. An executed instruction passes through dispatch and
// fetch, register read and execute, and LW adds a step for the extra lane-RAM
// read; a program load or a step that ends at once completes in the dispatch
// step. A one-word input buffer takes the next word while the current one
// executes and a result register holds the finished word for the consumer.
// After reset the lane RAMs are zeroed one row per cycle, all MEM_BYTES/4 =
// 16384 rows, during which no input word is taken.
module five_instruction_cpu_step import fics_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fics_in_if.sink    in_i,
  fics_out_if.source out_o
);

  fsm_state_e state_q, state_d;

  logic           pend_valid_q;
  in_word_t       pend_q;
  logic           pend_take;

  logic           out_valid_q;
  result_t        out_q;
  result_t        res;
  logic           res_load;
  logic           out_free;

  logic [15:0]    pc_q, pc_d;
  logic           run_q, run_d;
  logic [31:0]    word_q, word_d;
  logic [15:0]    addr_q, addr_d;
  logic [ROW_W-1:0] clr_q;
  logic           clr_done;

  logic [NUM_LANES-1:0]            bank_we;
  logic [NUM_LANES-1:0]            bank_re;
  logic [NUM_LANES-1:0][ROW_W-1:0] bank_addr;
  logic [NUM_LANES-1:0][7:0]       bank_wdata;
  logic [NUM_LANES-1:0][7:0]       bank_rdata;

  logic [31:0]    rf_mem [GPR_COUNT];
  logic [GPR_COUNT-1:0] rf_valid_q;
  logic           rf_re;
  logic [3:0]     rf_raddr_a, rf_raddr_b;
  logic [31:0]    rda_q, rdb_q;
  logic           rf_we;
  logic [3:0]     rf_waddr;
  logic [31:0]    rf_wdata;

  logic [3:0]     dec_op, dec_rt, dec_rd;
  logic [33:0]    dsum;
  logic           daddr_bad;
  logic [15:0]    daddr;
  logic           lw_go;
  logic [15:0]    pc_plus4;
  logic           fetch_bad;
  logic           load_ok;
  logic           step_go;
  logic [31:0]    add_val;
  logic [31:0]    load_val;

  function automatic logic [ROW_W-1:0] lane_row(logic [15:0] a, logic [1:0] lane);
    logic [1:0]  ofs;
    logic [15:0] ba;
    ofs = lane - a[1:0];
    ba  = a + {14'd0, ofs};
    return ba[ROW_W+1:2];
  endfunction

  function automatic logic [7:0] lane_byte(logic [1:0] lo, logic [1:0] lane,
                                           logic [31:0] v);
    logic [1:0]  ofs;
    logic [31:0] sh;
    ofs = lane - lo;
    sh  = v >> {ofs, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [31:0] word_gather(logic [1:0] lo,
                                              logic [NUM_LANES-1:0][7:0] rd);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      w[8*i +: 8] = rd[2'(lo + 2'(i))];
    end
    return w;
  endfunction

  // byte-lane memories
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [7:0] lane_mem [MEM_ROWS];
    logic [7:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (bank_we[g]) begin
        lane_mem[bank_addr[g]] <= bank_wdata[g];
      end
      if (bank_re[g]) begin
        rdata_q <= lane_mem[bank_addr[g]];
      end
    end

    assign bank_rdata[g] = rdata_q;
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (rf_re) begin
      rda_q <= rf_valid_q[rf_raddr_a] ? rf_mem[rf_raddr_a] : rf_reset_value(rf_raddr_a);
      rdb_q <= rf_valid_q[rf_raddr_b] ? rf_mem[rf_raddr_b] : rf_reset_value(rf_raddr_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[rf_waddr] <= 1'b1;
    end
  end

  assign dec_op    = word_q[31:28];
  assign dec_rt    = word_q[23:20];
  assign dec_rd    = word_q[19:16];
  assign dsum      = {{2{rda_q[31]}}, rda_q} + {{14{word_q[19]}}, word_q[19:0]};
  assign daddr_bad = dsum[33] || (dsum > DATA_TOP);
  assign daddr     = dsum[15:0];
  assign lw_go     = (dec_op == OP_LW) && (dec_rt != '0) && !daddr_bad;
  assign pc_plus4  = pc_q + 16'd4;
  assign fetch_bad = (17'(pc_q) + 17'd3) >= MEM_LIMIT;
  assign load_ok   = (17'({pend_q.word_index, 2'b00}) + 17'd4) <= MEM_LIMIT;
  assign step_go   = pend_valid_q && (pend_q.opcode == ITEM_STEP) && run_q && !fetch_bad;
  assign add_val   = rda_q + rdb_q;
  assign load_val  = word_gather(addr_q[1:0], bank_rdata);
  assign out_free  = !out_valid_q || out_o.ready;
  assign clr_done  = clr_q == ROW_W'(MEM_ROWS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_done) state_d = S_IDLE;
      S_IDLE:  if (step_go) state_d = S_FETCH;
      S_FETCH: state_d = S_REG;
      S_REG: begin
        if (lw_go) begin
          state_d = S_MEM;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MEM:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    bank_we    = '0;
    bank_re    = '0;
    bank_addr  = '0;
    bank_wdata = '0;
    rf_re      = 1'b0;
    rf_raddr_a = '0;
    rf_raddr_b = '0;
    rf_we      = 1'b0;
    rf_waddr   = '0;
    rf_wdata   = '0;
    pend_take  = 1'b0;
    res_load   = 1'b0;
    res        = '0;
    res.status = ST_OK;
    pc_d       = pc_q;
    run_d      = run_q;
    word_d     = word_q;
    addr_d     = addr_q;

    unique case (state_q)
      S_CLEAR: begin
        bank_we = '1;
        for (int k = 0; k < NUM_LANES; k++) begin
          bank_addr[k] = clr_q;
        end
      end
      S_IDLE: begin
        if (pend_valid_q) begin
          if (pend_q.opcode == ITEM_LOAD) begin
            if (out_free) begin
              pend_take = 1'b1;
              res_load  = 1'b1;
              if (load_ok) begin
                bank_we = '1;
                for (int k = 0; k < NUM_LANES; k++) begin
                  bank_addr[k]  = lane_row({pend_q.word_index, 2'b00}, 2'(k));
                  bank_wdata[k] = lane_byte(2'b00, 2'(k), pend_q.word_data);
                end
              end
            end
          end else if (!run_q) begin
            if (out_free) begin
              pend_take  = 1'b1;
              res_load   = 1'b1;
              res.status = ST_HALTED;
            end
          end else if (fetch_bad) begin
            if (out_free) begin
              pend_take  = 1'b1;
              res_load   = 1'b1;
              run_d      = 1'b0;
              res.status = ST_FETCH_RANGE;
            end
          end else begin
            pend_take = 1'b1;
            bank_re   = '1;
            for (int k = 0; k < NUM_LANES; k++) begin
              bank_addr[k] = lane_row(pc_q, 2'(k));
            end
          end
        end
      end
      S_FETCH: begin
        word_d     = word_gather(2'b00, bank_rdata);
        rf_re      = 1'b1;
        rf_raddr_a = word_d[27:24];
        rf_raddr_b = word_d[23:20];
      end
      S_REG: begin
        if (lw_go) begin
          addr_d  = daddr;
          bank_re = '1;
          for (int k = 0; k < NUM_LANES; k++) begin
            bank_addr[k] = lane_row(daddr, 2'(k));
          end
        end else if (out_free) begin
          res_load       = 1'b1;
          res.instr_word = word_q;
          pc_d           = pc_plus4;
          unique case (dec_op)
            OP_ADD: begin
              if (dec_rd == '0) begin
                res.status = ST_R0_SKIP;
              end else begin
                rf_we         = 1'b1;
                rf_waddr      = dec_rd;
                rf_wdata      = add_val;
                res.reg_write = 1'b1;
                res.reg_index = dec_rd;
                res.reg_value = add_val;
              end
            end
            OP_LW: begin
              if (dec_rt == '0) begin
                res.status = ST_R0_SKIP;
              end else begin
                run_d      = 1'b0;
                res.status = ST_BAD_ADDR;
              end
            end
            OP_SW: begin
              if (daddr_bad) begin
                run_d      = 1'b0;
                res.status = ST_BAD_ADDR;
              end else begin
                bank_we = '1;
                for (int k = 0; k < NUM_LANES; k++) begin
                  bank_addr[k]  = lane_row(daddr, 2'(k));
                  bank_wdata[k] = lane_byte(daddr[1:0], 2'(k), rdb_q);
                end
                res.mem_write   = 1'b1;
                res.mem_address = daddr;
              end
            end
            OP_BEQ: begin
              if (rda_q == rdb_q) begin
                pc_d             = pc_plus4 + {word_q[13:0], 2'b00};
                res.branch_taken = 1'b1;
              end
            end
            OP_J: begin
              pc_d = {word_q[13:0], 2'b00};
            end
            default: begin
              run_d      = 1'b0;
              res.status = ST_BAD_OP;
            end
          endcase
        end
      end
      S_MEM: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.instr_word = word_q;
          pc_d           = pc_plus4;
          rf_we          = 1'b1;
          rf_waddr       = dec_rt;
          rf_wdata       = load_val;
          res.reg_write  = 1'b1;
          res.reg_index  = dec_rt;
          res.reg_value  = load_val;
        end
      end
      default: begin
      end
    endcase

    res.next_pc = pc_d;
    res.halted  = !run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      run_q       <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      run_q   <= run_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ROW_W'(1);
      end
      if (in_i.valid && in_i.ready) begin
        pend_valid_q <= 1'b1;
      end else if (pend_take) begin
        pend_valid_q <= 1'b0;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    addr_q <= addr_d;
    if (in_i.valid && in_i.ready) begin
      pend_q.opcode     <= in_i.opcode;
      pend_q.word_index <= in_i.word_index;
      pend_q.word_data  <= in_i.word_data;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  assign in_i.ready         = !pend_valid_q && (state_q != S_CLEAR);
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.next_pc      = out_q.next_pc;
  assign out_o.halted       = out_q.halted;
  assign out_o.instr_word   = out_q.instr_word;
  assign out_o.reg_write    = out_q.reg_write;
  assign out_o.reg_index    = out_q.reg_index;
  assign out_o.reg_value    = out_q.reg_value;
  assign out_o.mem_write    = out_q.mem_write;
  assign out_o.mem_address  = out_q.mem_address;
  assign out_o.branch_taken = out_q.branch_taken;

`ifndef SYNTHESIS
  ap_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (rf_waddr != '0))
    else $error("register r0 written");

  ap_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_o.ready))
    else $error("result word overwritten before it was taken");

  ap_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("input taken during memory clear");

  ap_halt_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> $stable(pc_q))
    else $error("pc moved while halted");
`endif

endmodule

@@ tb/cpu_step_monitor.sv @@
`timescale 1ns / 100ps

module cpu_step_monitor import fics_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fics_in_if   in_chan_i,
  fics_out_if  out_chan_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  logic [7:0]  ram_bytes [MEM_BYTES];
  logic [31:0] gpr [GPR_COUNT];
  logic [15:0] pc_q;
  bit          running_q;
  result_t     expected_results [$];
  int          mismatches;
  int          checked;

  function automatic void clear_model();
    foreach (ram_bytes[i]) ram_bytes[i] = '0;
    foreach (gpr[i]) gpr[i] = (i == GPR_COUNT - 1) ? 32'(MEM_BYTES - 4) : '0;
    pc_q      = '0;
    running_q = 1'b1;
  endfunction

  function automatic logic [31:0] fetch_word(int a);
    return {ram_bytes[a + 3], ram_bytes[a + 2], ram_bytes[a + 1], ram_bytes[a]};
  endfunction

  function automatic void store_word(int a, logic [31:0] v);
    ram_bytes[a]     = v[7:0];
    ram_bytes[a + 1] = v[15:8];
    ram_bytes[a + 2] = v[23:16];
    ram_bytes[a + 3] = v[31:24];
  endfunction

  function automatic result_t predict_item(in_word_t w);
    result_t     r;
    logic [31:0] insn;
    logic [3:0]  rs, rt, rd;
    logic [15:0] inc;
    longint      ea;
    bit          bad_ea;
    int          slot;
    r = '0;
    r.status = ST_OK;
    if (w.opcode == ITEM_LOAD) begin
      slot = int'(w.word_index) * 4;
      if (slot + 4 <= MEM_BYTES) store_word(slot, w.word_data);
    end else if (!running_q) begin
      r.status = ST_HALTED;
    end else if (int'(pc_q) + 3 >= MEM_BYTES) begin
      running_q = 1'b0;
      r.status  = ST_FETCH_RANGE;
    end else begin
      insn = fetch_word(int'(pc_q));
      r.instr_word = insn;
      rs  = insn[27:24];
      rt  = insn[23:20];
      rd  = insn[19:16];
      ea  = longint'($signed(gpr[rs])) + longint'($signed(insn[19:0]));
      bad_ea = (ea < 0) || (ea + 3 >= MEM_BYTES);
      inc = 16'd4;
      case (instr_op_e'(insn[31:28]))
        OP_ADD: begin
          if (rd == 4'd0) begin
            r.status = ST_R0_SKIP;
          end else begin
            gpr[rd]     = gpr[rs] + gpr[rt];
            r.reg_write = 1'b1;
            r.reg_index = rd;
            r.reg_value = gpr[rd];
          end
        end
        OP_LW: begin
          if (rt == 4'd0) begin
            r.status = ST_R0_SKIP;
          end else if (bad_ea) begin
            running_q = 1'b0;
            r.status  = ST_BAD_ADDR;
          end else begin
            gpr[rt]     = fetch_word(int'(ea));
            r.reg_write = 1'b1;
            r.reg_index = rt;
            r.reg_value = gpr[rt];
          end
        end
        OP_SW: begin
          if (bad_ea) begin
            running_q = 1'b0;
            r.status  = ST_BAD_ADDR;
          end else begin
            store_word(int'(ea), gpr[rt]);
            r.mem_write   = 1'b1;
            r.mem_address = ea[15:0];
          end
        end
        OP_BEQ: begin
          if (gpr[rs] == gpr[rt]) begin
            inc = 16'd4 + {insn[13:0], 2'b00};
            r.branch_taken = 1'b1;
          end
        end
        OP_J: begin
          inc  = 16'd0;
          pc_q = {insn[13:0], 2'b00};
        end
        default: begin
          running_q = 1'b0;
          r.status  = ST_BAD_OP;
        end
      endcase
      pc_q = pc_q + inc;
    end
    r.next_pc = pc_q;
    r.halted  = !running_q;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result word arrived with nothing expected");
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    checked++;
    check_field("status", 32'(want.status), 32'(out_chan_i.status));
    check_field("next_pc", 32'(want.next_pc), 32'(out_chan_i.next_pc));
    check_field("halted", 32'(want.halted), 32'(out_chan_i.halted));
    check_field("instr_word", want.instr_word, out_chan_i.instr_word);
    check_field("reg_write", 32'(want.reg_write), 32'(out_chan_i.reg_write));
    check_field("reg_index", 32'(want.reg_index), 32'(out_chan_i.reg_index));
    check_field("reg_value", want.reg_value, out_chan_i.reg_value);
    check_field("mem_write", 32'(want.mem_write), 32'(out_chan_i.mem_write));
    check_field("mem_address", 32'(want.mem_address), 32'(out_chan_i.mem_address));
    check_field("branch_taken", 32'(want.branch_taken), 32'(out_chan_i.branch_taken));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_results.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_chan_i.valid && out_chan_i.ready) check_result();
      if (in_chan_i.valid && in_chan_i.ready) begin
        expected_results.push_back(predict_item(in_word_t'({in_chan_i.opcode,
            in_chan_i.word_index, in_chan_i.word_data})));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fics_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 450;

  typedef enum int {
    HALT_BAD_OP,
    HALT_LW_LOW,
    HALT_LW_HIGH,
    HALT_SW_LOW,
    HALT_SW_HIGH
  } halt_way_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   cycle_count;
  int   items_sent;
  int   loads_sent;
  int   steps_sent;
  int   src_calm;
  int   sink_calm;
  int   sink_hold;
  logic [15:0] pc_track;
  halt_way_e   halt_way;

  fics_in_if  in_w ();
  fics_out_if out_w ();

  five_instruction_cpu_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  cpu_step_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan_i    (in_w),
    .out_chan_i   (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("five_instruction_cpu_step test failed");
      $finish;
    end
  end

  function automatic int pick_gap(inout int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // stall the result side
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_w.ready = 1'b0;
      sink_hold--;
    end else begin
      out_w.ready = 1'b1;
      sink_hold = $urandom_range(0, 1) ? pick_gap(sink_calm) : 0;
    end
  end

  task automatic feed(item_op_e op, logic [13:0] idx, logic [31:0] data);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_w.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_w.valid      = 1'b1;
    in_w.opcode     = op;
    in_w.word_index = idx;
    in_w.word_data  = data;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
    items_sent++;
    if (op == ITEM_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  task automatic step_once();
    feed(ITEM_STEP, 14'($urandom), $urandom);
  endtask

  // place the word at the current pc, execute it, follow the pc
  task automatic run_insn(logic [31:0] insn);
    feed(ITEM_LOAD, pc_track[15:2], insn);
    step_once();
    case (instr_op_e'(insn[31:28]))
      OP_J:    pc_track = {insn[13:0], 2'b00};
      OP_BEQ:  pc_track += (insn[27:24] == insn[23:20]) ? 16'd4 + {insn[13:0], 2'b00} : 16'd4;
      default: pc_track += 16'd4;
    endcase
  endtask

  // r0 stays 0 and r15 stays at the top word, so these bases give legal addresses
  function automatic logic [23:0] safe_base_offset();
    logic [15:0] off;
    case ($urandom_range(0, 5))
      0:       off = 16'd0;
      1:       off = 16'hFFFC;
      default: off = 16'($urandom_range(0, 65532));
    endcase
    if ($urandom_range(0, 1)) return {4'd0, 20'(off)};
    return {4'd15, 20'(-int'(off))};
  endfunction

  function automatic logic [31:0] pick_insn(bit straight);
    int unsigned sel;
    logic [3:0]  rs, rt;
    logic [23:0] base_off;
    sel      = $urandom_range(0, straight ? 59 : 99);
    rs       = 4'($urandom);
    rt       = 4'($urandom);
    base_off = safe_base_offset();
    if (sel < 25) begin
      if ($urandom_range(0, 19) == 0) return {OP_ADD, 4'd15, 4'd0, 4'd15, 16'($urandom)};
      return {OP_ADD, rs, rt, 4'($urandom_range(0, 14)), 16'($urandom)};
    end
    if (sel < 45) begin
      rt = 4'($urandom_range(0, 14));
      if (rt == 4'd0) return {OP_LW, rs, rt, 20'($urandom)};
      return {OP_LW, base_off[23:20], rt, base_off[19:0]};
    end
    if (sel < 60) begin
      if ($urandom_range(0, 1)) return {OP_BEQ, 4'd0, 4'd15, 20'($urandom)};
      return {OP_BEQ, 4'd15, 4'd0, 20'($urandom)};
    end
    if (sel < 75) return {OP_SW, base_off[23:20], rt, base_off[19:0]};
    if (sel < 88) return {OP_BEQ, rs, rs, 20'($urandom)};
    return {OP_J, 28'($urandom)};
  endfunction

  initial begin
    int n;
    logic [31:0] insn;
    cycle_count     = 0;
    items_sent      = 0;
    loads_sent      = 0;
    steps_sent      = 0;
    src_calm        = 0;
    sink_calm       = 0;
    sink_hold       = 0;
    pc_track        = '0;
    in_w.valid      = 1'b0;
    in_w.opcode     = ITEM_STEP;
    in_w.word_index = '0;
    in_w.word_data  = '0;
    out_w.ready     = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty memory decodes as an add to r0
    feed(ITEM_STEP, '0, '0);
    pc_track = 16'd4;
    feed(ITEM_LOAD, 14'h3FFF, 32'hFFFF_FFFF);
    run_insn({OP_LW, 4'd0, 4'd3, 20'h0FFFC});
    run_insn({OP_ADD, 4'd3, 4'd3, 4'd4, 16'h0000});
    run_insn({OP_ADD, 4'd15, 4'd15, 4'd1, 16'hFFFF});
    run_insn({OP_LW, 4'd3, 4'd0, 20'h7FFFF});
    run_insn({OP_SW, 4'd15, 4'd4, 20'h00000});
    run_insn({OP_SW, 4'd15, 4'd3, 20'hF0004});
    run_insn({OP_LW, 4'd0, 4'd5, 20'h00000});
    run_insn({OP_LW, 4'd0, 4'd6, 20'h00001});
    run_insn({OP_BEQ, 4'd0, 4'd15, 20'h12345});
    run_insn({OP_BEQ, 4'd3, 4'd3, 20'h7FFFF});
    run_insn({OP_BEQ, 4'd3, 4'd3, 20'h80000});
    run_insn({OP_BEQ, 4'd3, 4'd3, 20'hFFFFD});
    run_insn({OP_J, 28'hFFF_FFFF});
    run_insn({OP_ADD, 4'd1, 4'd4, 4'd2, 16'h0000});
    run_insn({OP_J, 28'h000_0000});

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 3)) feed(ITEM_LOAD, 14'($urandom), $urandom);
        end
        2, 3, 4: begin
          // load a straight run of code, then execute it
          n = $urandom_range(2, 8);
          for (int k = 0; k < n; k++) feed(ITEM_LOAD, 14'(pc_track[15:2] + k), pick_insn(1'b1));
          repeat (n) begin
            step_once();
            pc_track += 16'd4;
          end
        end
        default: run_insn(pick_insn(1'b0));
      endcase
    end

    // stop the processor, then poke it while halted
    halt_way = halt_way_e'($urandom_range(0, 4));
    case (halt_way)
      HALT_BAD_OP:  insn = {4'($urandom_range(5, 15)), 28'($urandom)};
      HALT_LW_LOW:  insn = {OP_LW, 4'd0, 4'($urandom_range(1, 14)),
                            20'(-int'($urandom_range(1, 65536)))};
      HALT_LW_HIGH: insn = {OP_LW, 4'd15, 4'($urandom_range(1, 14)),
                            20'($urandom_range(1, 524287))};
      HALT_SW_LOW:  insn = {OP_SW, 4'd0, 4'($urandom), 20'(-int'($urandom_range(1, 524288)))};
      default:      insn = {OP_SW, 4'd15, 4'($urandom), 20'($urandom_range(1, 524287))};
    endcase
    run_insn(insn);
    repeat (3) step_once();
    repeat (2) feed(ITEM_LOAD, 14'($urandom), $urandom);
    step_once();
    in_w.valid = 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Sent %0d program loads and %0d steps; %0d result words checked.",
             loads_sent, steps_sent, checked_count);
    $display("Processor stopped by %s, then stepped and loaded while halted.",
             halt_way.name());
    if (fail_count == 0) begin
      $display("five_instruction_cpu_step test passed");
    end else begin
      $display("five_instruction_cpu_step test failed");
    end
    $finish;
  end

endmodule
